// ===== src/kcpr_pkg.sv =====
// Shared types and constants for the key capture priority router.
// No dependencies; imported by every module of the block.
`default_nettype none
package kcpr_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_END_SCAN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_POWER_SCAN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_KEY    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_POWER_KEY  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SYSTEM_APP = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_HOME_APP   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_LONG_MOD   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_COMBINED   = 3'd7;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_CANCEL = 2'd2;
  localparam logic [1:0] FUNC_ROUTE  = 2'd3;

  localparam logic [1:0] TYPE_SCAN = 2'd0;
  localparam logic [1:0] TYPE_BAD  = 2'd3;

  localparam logic [2:0] ST_ROUTED    = 3'd0;
  localparam logic [2:0] ST_CAPTURED  = 3'd1;
  localparam logic [2:0] ST_DONE      = 3'd2;
  localparam logic [2:0] ST_BAD_ARG   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  capture_type;
    logic [31:0] code;
    logic [15:0] scan_code;
    logic [31:0] modifiers;
    logic [31:0] modifier_mask;
    logic [31:0] priority_req;
    logic [31:0] window_group;
    logic [31:0] handle;
    logic [31:0] app_id;
    logic [31:0] output_code;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] dest_window_group;
    logic [15:0] out_scan_code;
    logic [31:0] out_key_code;
    logic [31:0] out_modifiers;
    logic [31:0] capture_handle;
  } rsp_t;

  typedef struct packed {
    logic [15:0] end_scan;
    logic [15:0] power_scan;
    logic [31:0] end_key;
    logic [31:0] power_key;
    logic [31:0] system_app;
    logic [31:0] home_app;
    logic [31:0] long_mod;
    logic        combined;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request
    logic scan;     // run match / handle search, one slot per cycle
    logic scan_clr; // clear search pointer and found flag
    logic commit;   // apply add/update/cancel, build response
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/kcpr_ctrl.sv =====
// Controller for the key capture priority router.
// Depends on kcpr_pkg; drives kcpr_dp through cmd_t / sts_t.
`default_nettype none
module kcpr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  output kcpr_pkg::cmd_t      cmd,
  input  kcpr_pkg::sts_t      sts,
  output logic                busy,
  output logic                out_tvalid,
  input  wire logic           out_tready
);
  import kcpr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_OUT} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
endmodule
`default_nettype wire

// ===== src/kcpr_dp.sv =====
// Datapath: capture table, serial match/priority search, response build.
// Depends on kcpr_pkg; sequenced by kcpr_ctrl.
`default_nettype none
module kcpr_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  kcpr_pkg::cmd_t      cmd,
  output kcpr_pkg::sts_t      sts,
  input  kcpr_pkg::req_t      req_in,
  input  kcpr_pkg::cfg_t      cfg,
  output kcpr_pkg::rsp_t      rsp
);
  import kcpr_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef struct packed {
    logic [1:0]  ctype;
    logic [31:0] code;
    logic [31:0] mask;
    logic [31:0] mval;
    logic [31:0] prio;
    logic [31:0] group;
    logic [31:0] handle;
    logic [31:0] app;
    logic [31:0] ocode;
  } slot_t;

  slot_t                 slot_r [CAPACITY];
  logic [CAPACITY-1:0]   valid_r;
  req_t                  req_r;
  rsp_t                  rsp_r;
  rsp_t                  rsp_nxt;
  logic [IdxW-1:0]       ptr_r;
  logic                  found_r;
  logic [IdxW-1:0]       best_r;
  logic signed [31:0]    best_prio_r;

  slot_t cur;
  logic  key_hit, hdl_hit;
  logic [31:0] key;

  assign cur = slot_r[ptr_r];
  assign key = (req_r.capture_type == TYPE_SCAN) ? {16'd0, req_r.scan_code} : req_r.code;
  assign key_hit = valid_r[ptr_r] && cur.ctype == req_r.capture_type && cur.code == key &&
                   (req_r.modifiers & cur.mask) == cur.mval;
  assign hdl_hit = valid_r[ptr_r] && cur.handle == req_r.handle;
  assign sts.scan_last = (ptr_r == IdxW'(CAPACITY - 1));

  // search: route keeps strictly greater priority; handle search keeps first hit
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= req_in;
    if (cmd.scan_clr) begin
      ptr_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan) begin
      if (!sts.scan_last) ptr_r <= ptr_r + 1'b1;
      if (req_r.func == FUNC_ROUTE) begin
        if (key_hit && (!found_r || $signed(cur.prio) > best_prio_r)) begin
          found_r     <= 1'b1;
          best_r      <= ptr_r;
          best_prio_r <= $signed(cur.prio);
        end
      end else if (hdl_hit && !found_r) begin
        found_r <= 1'b1;
        best_r  <= ptr_r;
      end
    end
  end

  logic  bad;
  logic [31:0] add_code;
  slot_t new_slot, bs;
  logic  sys;

  always_comb begin
    bad = ((req_r.modifiers & ~req_r.modifier_mask) != 32'd0) ||
          (((req_r.modifier_mask & cfg.long_mod) != 32'd0) && req_r.window_group != 32'd0) ||
          (req_r.priority_req == 32'h8000_0000) || (req_r.capture_type == TYPE_BAD);
    add_code = req_r.code;
    if (cfg.combined) begin
      if (req_r.capture_type == TYPE_SCAN) begin
        if (req_r.code == {16'd0, cfg.end_scan}) add_code = {16'd0, cfg.power_scan};
      end else if (req_r.code == cfg.end_key) begin
        add_code = cfg.power_key;
      end
    end
    // only an add translates the end code
    new_slot = '{ctype: req_r.capture_type,
                 code: (req_r.func == FUNC_ADD) ? add_code : req_r.code,
                 mask: req_r.modifier_mask,
                 mval: req_r.modifiers, prio: req_r.priority_req,
                 group: req_r.window_group, handle: req_r.handle, app: req_r.app_id,
                 ocode: req_r.output_code};
    bs  = slot_r[best_r];
    sys = cfg.combined && bs.app == cfg.system_app;
  end

  always_comb begin
    rsp_nxt = '0;
    case (req_r.func)
      FUNC_ADD: begin
        if (bad) rsp_nxt.status = ST_BAD_ARG;
        else if (valid_r[CAPACITY-1]) rsp_nxt.status = ST_FULL;
        else rsp_nxt.status = ST_DONE;
      end
      FUNC_UPDATE: begin
        if (bad) rsp_nxt.status = ST_BAD_ARG;
        else if (!found_r) rsp_nxt.status = ST_NOT_FOUND;
        else rsp_nxt.status = ST_DONE;
      end
      FUNC_CANCEL: begin
        if (!found_r) rsp_nxt.status = ST_NOT_FOUND;
        else rsp_nxt.status = ST_DONE;
      end
      default: begin
        rsp_nxt.out_modifiers = req_r.modifiers;
        rsp_nxt.out_scan_code = req_r.scan_code;
        rsp_nxt.out_key_code  = req_r.code;
        if (!found_r) begin
          rsp_nxt.status            = ST_ROUTED;
          rsp_nxt.dest_window_group = req_r.window_group;
        end else begin
          rsp_nxt.status            = ST_CAPTURED;
          rsp_nxt.dest_window_group = bs.group;
          rsp_nxt.capture_handle    = bs.handle;
          if (req_r.capture_type == TYPE_SCAN) begin
            rsp_nxt.out_scan_code = bs.ocode[15:0];
            if (sys && req_r.scan_code == cfg.power_scan)
              rsp_nxt.out_scan_code = (req_r.app_id == cfg.home_app) ?
                                      cfg.power_scan : cfg.end_scan;
          end else begin
            rsp_nxt.out_key_code = bs.ocode;
            if (sys && req_r.code == cfg.power_key)
              rsp_nxt.out_key_code = (req_r.app_id == cfg.home_app) ?
                                     cfg.power_key : cfg.end_key;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_r <= rsp_nxt;
      case (req_r.func)
        FUNC_ADD: begin
          if (!bad && !valid_r[CAPACITY-1]) begin
            for (int i = CAPACITY - 1; i > 0; i--) slot_r[i] <= slot_r[i-1];
            slot_r[0] <= new_slot;
          end
        end
        FUNC_UPDATE: begin
          if (!bad && found_r) slot_r[best_r] <= new_slot;
        end
        FUNC_CANCEL: begin
          if (found_r) begin
            for (int i = 0; i < CAPACITY - 1; i++)
              if (IdxW'(i) >= best_r) slot_r[i] <= slot_r[i+1];
          end
        end
        default: ;
      endcase
    end
  end

  // valid bits: always a prefix
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (cmd.commit) begin
      if (req_r.func == FUNC_ADD && !bad && !valid_r[CAPACITY-1])
        valid_r <= {valid_r[CAPACITY-2:0], 1'b1};
      else if (req_r.func == FUNC_CANCEL && found_r)
        valid_r <= {1'b0, valid_r[CAPACITY-1:1]};
    end
  end

  assign rsp = rsp_r;
endmodule
`default_nettype wire

// ===== src/kcpr_cfg.sv =====
// Configuration register file for the key capture priority router.
// Depends on kcpr_pkg.
`default_nettype none
module kcpr_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [kcpr_pkg::CfgIdxW-1:0]  wr_idx,
  input  wire logic [31:0]                   wr_data,
  output kcpr_pkg::cfg_t                     cfg
);
  import kcpr_pkg::*;
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else if (wr_en) begin
      case (wr_idx)
        CFG_END_SCAN:   cfg_r.end_scan   <= wr_data[15:0];
        CFG_POWER_SCAN: cfg_r.power_scan <= wr_data[15:0];
        CFG_END_KEY:    cfg_r.end_key    <= wr_data;
        CFG_POWER_KEY:  cfg_r.power_key  <= wr_data;
        CFG_SYSTEM_APP: cfg_r.system_app <= wr_data;
        CFG_HOME_APP:   cfg_r.home_app   <= wr_data;
        CFG_LONG_MOD:   cfg_r.long_mod   <= wr_data;
        CFG_COMBINED:   cfg_r.combined   <= wr_data[0];
        default: ;
      endcase
    end
  end
  assign cfg = cfg_r;
endmodule
`default_nettype wire

// ===== src/key_capture_priority_router.sv =====
// Top level of the key capture priority router.
// Depends on kcpr_pkg, kcpr_cfg, kcpr_ctrl and kcpr_dp.
//
// Usage:
//   in_*   : one request per transaction (add, update, cancel or route).
//   out_*  : exactly one response per request, in order.
//   cfg_*  : register writes, index 0..7; write only while the block is idle.
// Sequence: a request is taken in S_IDLE, the table is then walked one slot
// per cycle in S_SCAN (through one comparator and priority compare), and
// S_COMMIT applies the table change and registers the response, which S_OUT
// then presents on out_*. One request is in flight at a time: no new
// request is accepted until the response has been taken.
// Reset: all table entries become invalid, the configuration registers go to zero.
// Stall: the response holds on out_* while out_tready is low; no new request
// is accepted until it is taken.
`default_nettype none
module key_capture_priority_router #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: capture_type[1:0], code[33:2], scan_code[49:34], modifiers[81:50],
  // modifier_mask[113:82], priority_req[145:114], window_group[177:146],
  // handle[209:178], app_id[241:210], output_code[273:242], zero fill
  input  wire logic [279:0] in_tdata,
  input  wire logic [1:0]   in_tuser,   // func[1:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: dest_window_group[31:0], out_scan_code[47:32], out_key_code[79:48],
  // out_modifiers[111:80], capture_handle[143:112]
  output logic [143:0]      out_tdata,
  output logic [2:0]        out_tuser,  // status[2:0]
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [kcpr_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import kcpr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  cfg_t cfg;
  req_t req;
  rsp_t rsp;
  logic busy;

  assign in_tready = !busy;
  assign cfg_ready = 1'b1;

  assign req = '{func: in_tuser, capture_type: in_tdata[1:0], code: in_tdata[33:2],
                 scan_code: in_tdata[49:34], modifiers: in_tdata[81:50],
                 modifier_mask: in_tdata[113:82], priority_req: in_tdata[145:114],
                 window_group: in_tdata[177:146], handle: in_tdata[209:178],
                 app_id: in_tdata[241:210], output_code: in_tdata[273:242]};

  kcpr_cfg u_cfg (
    .clk, .rst_n, .wr_en(cfg_valid), .wr_idx(cfg_index), .wr_data(cfg_data), .cfg
  );

  kcpr_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(in_tvalid && in_tready), .cmd, .sts, .busy,
    .out_tvalid, .out_tready
  );

  kcpr_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst_n, .cmd, .sts, .req_in(req), .cfg, .rsp
  );

  assign out_tuser = rsp.status;
  assign out_tdata = {rsp.capture_handle, rsp.out_modifiers, rsp.out_key_code,
                      rsp.out_scan_code, rsp.dest_window_group};
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for key_capture_priority_router.
// Depends on kcpr_pkg and the RTL; a scoreboard class predicts each response.
`default_nettype none

class capture_table_sb;
  localparam int Depth = 16;
  logic [15:0] end_scan, power_scan;
  logic [31:0] end_key, power_key, system_app, home_app, long_mod;
  logic        combined;
  bit          vld[Depth];
  logic [1:0]  e_type[Depth];
  logic [31:0] e_code[Depth], e_mask[Depth], e_value[Depth], e_prio[Depth];
  logic [31:0] e_group[Depth], e_handle[Depth], e_app[Depth], e_out[Depth];
  kcpr_pkg::rsp_t pending[$];
  int mismatches;

  function new();
    end_scan = 0; power_scan = 0; end_key = 0; power_key = 0;
    system_app = 0; home_app = 0; long_mod = 0; combined = 0;
    foreach (vld[i]) vld[i] = 0;
    mismatches = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      kcpr_pkg::CFG_END_SCAN:   end_scan = v[15:0];
      kcpr_pkg::CFG_POWER_SCAN: power_scan = v[15:0];
      kcpr_pkg::CFG_END_KEY:    end_key = v;
      kcpr_pkg::CFG_POWER_KEY:  power_key = v;
      kcpr_pkg::CFG_SYSTEM_APP: system_app = v;
      kcpr_pkg::CFG_HOME_APP:   home_app = v;
      kcpr_pkg::CFG_LONG_MOD:   long_mod = v;
      default:                  combined = v[0];
    endcase
  endfunction

  function bit rejected(kcpr_pkg::req_t r);
    return ((r.modifiers & ~r.modifier_mask) != 0) ||
           ((r.modifier_mask & long_mod) != 0 && r.window_group != 0) ||
           (r.priority_req == 32'h8000_0000) || (r.capture_type == kcpr_pkg::TYPE_BAD);
  endfunction

  function void fill(int i, kcpr_pkg::req_t r, logic [31:0] c);
    vld[i] = 1; e_type[i] = r.capture_type; e_code[i] = c;
    e_value[i] = r.modifiers; e_mask[i] = r.modifier_mask; e_prio[i] = r.priority_req;
    e_group[i] = r.window_group; e_handle[i] = r.handle; e_app[i] = r.app_id;
    e_out[i] = r.output_code;
  endfunction

  function void move(int d, int s);
    vld[d] = vld[s]; e_type[d] = e_type[s]; e_code[d] = e_code[s];
    e_value[d] = e_value[s]; e_mask[d] = e_mask[s]; e_prio[d] = e_prio[s];
    e_group[d] = e_group[s]; e_handle[d] = e_handle[s]; e_app[d] = e_app[s];
    e_out[d] = e_out[s];
  endfunction

  function int lookup(logic [31:0] h);
    for (int i = 0; i < Depth; i++) if (vld[i] && e_handle[i] == h) return i;
    return -1;
  endfunction

  function int live_count();
    int n;
    n = 0;
    foreach (vld[i]) n += vld[i];
    return n;
  endfunction

  function void note_request(kcpr_pkg::req_t r);
    kcpr_pkg::rsp_t p;
    logic [31:0] c, key, os, ok;
    int k, best;
    logic signed [31:0] bp;
    bit sys;
    p = '0;
    case (r.func)
      kcpr_pkg::FUNC_ADD: begin
        if (rejected(r)) p.status = kcpr_pkg::ST_BAD_ARG;
        else if (vld[Depth-1]) p.status = kcpr_pkg::ST_FULL;
        else begin
          c = r.code;
          if (combined) begin
            if (r.capture_type == kcpr_pkg::TYPE_SCAN) begin
              if (c == {16'h0, end_scan}) c = {16'h0, power_scan};
            end else if (c == end_key) c = power_key;
          end
          for (int i = Depth - 1; i > 0; i--) move(i, i - 1);
          fill(0, r, c);
          p.status = kcpr_pkg::ST_DONE;
        end
      end
      kcpr_pkg::FUNC_UPDATE: begin
        k = lookup(r.handle);
        if (rejected(r)) p.status = kcpr_pkg::ST_BAD_ARG;
        else if (k < 0) p.status = kcpr_pkg::ST_NOT_FOUND;
        else begin
          fill(k, r, r.code);
          p.status = kcpr_pkg::ST_DONE;
        end
      end
      kcpr_pkg::FUNC_CANCEL: begin
        k = lookup(r.handle);
        if (k < 0) p.status = kcpr_pkg::ST_NOT_FOUND;
        else begin
          for (int i = k; i < Depth - 1; i++) move(i, i + 1);
          vld[Depth-1] = 0;
          p.status = kcpr_pkg::ST_DONE;
        end
      end
      default: begin
        key = (r.capture_type == kcpr_pkg::TYPE_SCAN) ? {16'h0, r.scan_code} : r.code;
        best = -1; bp = 0;
        for (int i = 0; i < Depth; i++)
          if (vld[i] && e_type[i] == r.capture_type && e_code[i] == key &&
              (r.modifiers & e_mask[i]) == e_value[i] &&
              (best < 0 || $signed(e_prio[i]) > bp)) begin
            best = i; bp = e_prio[i];
          end
        p.out_modifiers = r.modifiers;
        if (best < 0) begin
          p.status = kcpr_pkg::ST_ROUTED;
          p.dest_window_group = r.window_group;
          p.out_scan_code = r.scan_code;
          p.out_key_code = r.code;
        end else begin
          os = {16'h0, r.scan_code}; ok = r.code;
          sys = combined && e_app[best] == system_app;
          if (r.capture_type == kcpr_pkg::TYPE_SCAN) begin
            os = e_out[best];
            if (sys && r.scan_code == power_scan)
              os = (r.app_id == home_app) ? power_scan : end_scan;
          end else begin
            ok = e_out[best];
            if (sys && r.code == power_key) ok = (r.app_id == home_app) ? power_key : end_key;
          end
          p.status = kcpr_pkg::ST_CAPTURED;
          p.dest_window_group = e_group[best];
          p.out_scan_code = os[15:0];
          p.out_key_code = ok;
          p.capture_handle = e_handle[best];
        end
      end
    endcase
    pending.push_back(p);
  endfunction

  function void check_response(kcpr_pkg::rsp_t got);
    kcpr_pkg::rsp_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected response %h", got);
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status || got.dest_window_group !== want.dest_window_group ||
        got.out_scan_code !== want.out_scan_code || got.out_key_code !== want.out_key_code ||
        got.out_modifiers !== want.out_modifiers ||
        got.capture_handle !== want.capture_handle) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected st=%0d grp=%h sc=%h kc=%h mod=%h h=%h",
                 want.status, want.dest_window_group, want.out_scan_code,
                 want.out_key_code, want.out_modifiers, want.capture_handle,
                 "\n          actual   st=%0d grp=%h sc=%h kc=%h mod=%h h=%h",
                 got.status, got.dest_window_group, got.out_scan_code,
                 got.out_key_code, got.out_modifiers, got.capture_handle);
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kcpr_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_valid = 0;
  logic [279:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  wire in_tready, out_tvalid, cfg_ready;
  wire [143:0] out_tdata;
  wire [2:0] out_tuser;

  key_capture_priority_router u_dut (.*);

  always #4 clk = ~clk;

  capture_table_sb sb = new();
  int cycles = 0;
  int idle_pct = 38;     // chance in percent, out of 100
  int hold_off = 0;
  // handle pool kept small so update/cancel usually hit
  logic [31:0] handles[8] = '{32'h0, 32'h1, 32'h7, 32'hffff_ffff, 32'h55, 32'haa, 32'h1234, 32'h8000_0000};

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_response({out_tuser, out_tdata[31:0],
        out_tdata[47:32], out_tdata[79:48], out_tdata[111:80], out_tdata[143:112]});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else out_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send(req_t r);
    in_tvalid <= 1;
    in_tuser <= r.func;
    in_tdata <= {6'b0, r.output_code, r.app_id, r.handle, r.window_group, r.priority_req,
                 r.modifier_mask, r.modifiers, r.scan_code, r.code, r.capture_type};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      repeat (1 + $urandom_range(2)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_req(bit wellformed, logic [1:0] f);
    req_t r;
    r.func = f;
    r.capture_type = wellformed ? 2'($urandom_range(2)) : 2'($urandom_range(3));
    r.handle = handles[$urandom_range(7)];
    r.app_id = ($urandom_range(2) == 0) ? sb.system_app :
               ($urandom_range(1) ? sb.home_app : pick32());
    r.output_code = pick32();
    r.window_group = ($urandom_range(3) == 0) ? 32'h0 : pick32();
    r.priority_req = ($urandom_range(9) == 0) ? {1'b1, 31'h0} :
                     ($urandom_range(3) == 0 ? 32'h7fff_ffff : $urandom_range(3) - 1);
    r.scan_code = ($urandom_range(2) == 0) ? sb.power_scan : 16'($urandom_range(3));
    r.code = ($urandom_range(3) == 0) ? pick32() : $urandom_range(3);
    case ($urandom_range(3))
      0: r.code = sb.end_key;
      1: r.code = sb.power_key;
      default: ;
    endcase
    if (r.capture_type == TYPE_SCAN && $urandom_range(1)) r.code = {16'h0, r.scan_code};
    if (f == FUNC_ADD && r.capture_type == TYPE_SCAN && $urandom_range(3) == 0)
      r.code = {16'h0, sb.end_scan};
    r.modifier_mask = ($urandom_range(1)) ? 32'h0 : pick32();
    r.modifiers = wellformed ? (pick32() & r.modifier_mask) : pick32();
    return r;
  endfunction

  task automatic run_random(int n);
    logic [1:0] f;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2: f = FUNC_ADD;
        3: f = FUNC_UPDATE;
        4: f = FUNC_CANCEL;
        default: f = FUNC_ROUTE;
      endcase
      if (sb.live_count() > 13 && f == FUNC_ADD && $urandom_range(1)) f = FUNC_CANCEL;
      send(random_req($urandom_range(9) != 0, f));
    end
  endtask

  task automatic set_all(logic [31:0] es, logic [31:0] ps, logic [31:0] ek, logic [31:0] pk,
                         logic [31:0] sa, logic [31:0] ha, logic [31:0] lm, logic en);
    write_reg(CFG_END_SCAN, es); write_reg(CFG_POWER_SCAN, ps);
    write_reg(CFG_END_KEY, ek); write_reg(CFG_POWER_KEY, pk);
    write_reg(CFG_SYSTEM_APP, sa); write_reg(CFG_HOME_APP, ha);
    write_reg(CFG_LONG_MOD, lm); write_reg(CFG_COMBINED, {31'h0, en});
  endtask

  initial begin
    req_t r;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    set_all(32'h1, 32'h2, 32'h100058f3, 32'h20022f35, 32'h5, 32'h6, 32'h0001_0000, 1);

    // directed: errors, translation, priority ties, focus rule, full table
    r = '0; r.func = FUNC_CANCEL; r.handle = 32'h9; send(r);            // not found
    r.func = FUNC_UPDATE; send(r);                                       // not found
    r = '0; r.func = FUNC_ADD; r.capture_type = TYPE_BAD; send(r);       // bad type
    r.capture_type = 1; r.modifiers = 1; send(r);                        // mods outside mask
    r.modifiers = 0; r.modifier_mask = 32'h1_0000; r.window_group = 3; send(r); // long press
    r.modifier_mask = 0; r.priority_req = 32'h8000_0000; send(r);        // min priority
    r = '0; r.func = FUNC_ADD; r.capture_type = 1; r.code = 32'h100058f3;
    r.handle = 1; r.app_id = 5; r.output_code = 32'hffff_ffff; r.window_group = 32'hffff_ffff;
    send(r);                                                             // end -> power
    r.handle = 2; r.priority_req = 32'h7fff_ffff; r.app_id = 7; send(r);
    r.handle = 3; send(r);                                               // tie, newest wins
    r = '0; r.func = FUNC_ADD; r.capture_type = TYPE_SCAN; r.code = 1; r.handle = 4;
    r.app_id = 5; r.output_code = 32'h0001_abcd; send(r);                // scan end -> power
    r.code = 32'h1_0000; r.handle = 5; send(r);                          // wide, never matches
    r = '0; r.func = FUNC_ROUTE; r.capture_type = TYPE_SCAN; r.scan_code = 2; r.app_id = 6;
    r.modifiers = 32'hffff_ffff; send(r);
    r.app_id = 9; send(r);
    r.capture_type = 1; r.code = 32'h20022f35; send(r);
    r.capture_type = TYPE_BAD; send(r);
    r = '0; r.func = FUNC_UPDATE; r.handle = 3; r.capture_type = 2; r.code = 32'hffff_ffff;
    r.priority_req = 32'h8000_0001; send(r);
    r.func = FUNC_CANCEL; send(r);
    r = '0; r.func = FUNC_ADD; r.capture_type = 2; r.handle = 32'hffff_ffff;
    for (int i = 0; i < 14; i++) send(r);                                // fill, then full
    drain();

    run_random(150);
    drain();
    set_all(32'hffff, 32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 0);
    run_random(120);
    drain();
    set_all($urandom, $urandom, $urandom_range(3), $urandom_range(3),
            32'h0, 32'hffff_ffff, 32'h8000_0000, 1);
    idle_pct = 0;
    hold_off <= 300;                                                     // back-pressure
    run_random(140);
    idle_pct = 38;
    run_random(140);
    drain();
    if (sb.mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
src/kcpr_pkg.sv
src/kcpr_ctrl.sv
src/kcpr_dp.sv
src/kcpr_cfg.sv
src/key_capture_priority_router.sv
tb/tb.sv
